// File: hdl/wsfp_pkg.sv
// ---------------------------------------------------------------------------
// wsfp_pkg
// Shared types and codes for the WebSocket frame parser: result kinds,
// error codes, frame opcodes and the result record passed between stages.
// ---------------------------------------------------------------------------
package wsfp_pkg;

  localparam logic [2:0] KIND_MSG        = 3'd0;
  localparam logic [2:0] KIND_PING_BYTE  = 3'd1;
  localparam logic [2:0] KIND_PING_EMPTY = 3'd2;
  localparam logic [2:0] KIND_CLOSE      = 3'd3;
  localparam logic [2:0] KIND_ERROR      = 3'd4;

  localparam logic [2:0] ERR_RSV         = 3'd0;
  localparam logic [2:0] ERR_MASKED      = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG    = 3'd2;
  localparam logic [2:0] ERR_BAD_OPCODE  = 3'd3;
  localparam logic [2:0] ERR_BAD_CONTROL = 3'd4;
  localparam logic [2:0] ERR_CLOSE_ONE   = 3'd5;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] CTRL_MAX  = 7'd125;

  localparam logic [30:0] MAX_FRAME_RESET = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic        is_binary;
    logic [15:0] close_code;
    logic        has_close_code;
    logic [2:0]  error_code;
  } wsfp_result_t;

endpackage

// File: hdl/wsfp_front.sv
// ---------------------------------------------------------------------------
// wsfp_front
// Header walker: takes one received byte per transfer, tracks the frame
// header and payload, and produces at most one result record per byte.
// ---------------------------------------------------------------------------
module wsfp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_accept,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_write,
  input  logic [30:0]           cfg_value,
  output logic                  push,
  output wsfp_pkg::wsfp_result_t push_data
);

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_LEN,
    PH_EXT,
    PH_BODY,
    PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [30:0] max_frame_len;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        masked_flag, masked_flag_next;
  logic [3:0]  ext_len_left, ext_len_left_next;
  logic [3:0]  header_len, header_len_next;
  logic [63:0] payload_left, payload_left_next;
  logic [15:0] close_status, close_status_next;
  logic [1:0]  close_bytes_seen, close_bytes_seen_next;

  // Header-complete checks, evaluated on the candidate length and header size.
  logic [63:0] chk_len;
  logic [3:0]  chk_hlen;
  logic [31:0] chk_total;
  logic        chk_run;
  logic        opcode_ok;
  logic        is_ctrl;
  logic [63:0] body_dec;
  logic        body_end;

  function automatic logic chk_opcode_ok(input logic [3:0] op);
    logic ok;
    case (op)
      wsfp_pkg::OP_CONT, wsfp_pkg::OP_TEXT, wsfp_pkg::OP_BINARY,
      wsfp_pkg::OP_CLOSE, wsfp_pkg::OP_PING, wsfp_pkg::OP_PONG: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  always_comb begin
    phase_next            = phase;
    fin_flag_next         = fin_flag;
    frame_opcode_next     = frame_opcode;
    masked_flag_next      = masked_flag;
    ext_len_left_next     = ext_len_left;
    header_len_next       = header_len;
    payload_left_next     = payload_left;
    close_status_next     = close_status;
    close_bytes_seen_next = close_bytes_seen;
    push                  = 1'b0;
    push_data             = '0;
    chk_len               = '0;
    chk_hlen              = '0;
    chk_run               = 1'b0;
    body_dec              = payload_left - 64'd1;
    body_end              = (body_dec == 64'd0);

    case (phase)
      PH_FLAGS: begin
        if ((rx_byte & 8'h70) != 8'h00) begin
          phase_next           = PH_HALT;
          push                 = 1'b1;
          push_data.kind       = wsfp_pkg::KIND_ERROR;
          push_data.error_code = wsfp_pkg::ERR_RSV;
        end else begin
          fin_flag_next     = rx_byte[7];
          frame_opcode_next = rx_byte[3:0];
          phase_next        = PH_LEN;
        end
      end
      PH_LEN: begin
        masked_flag_next = rx_byte[7];
        if (rx_byte[6:0] == wsfp_pkg::LEN_EXT16) begin
          ext_len_left_next = 4'd2;
          header_len_next   = 4'd4;
          payload_left_next = '0;
          phase_next        = PH_EXT;
        end else if (rx_byte[6:0] == wsfp_pkg::LEN_EXT64) begin
          ext_len_left_next = 4'd8;
          header_len_next   = 4'd10;
          payload_left_next = '0;
          phase_next        = PH_EXT;
        end else begin
          ext_len_left_next = 4'd0;
          header_len_next   = 4'd2;
          payload_left_next = {57'd0, rx_byte[6:0]};
          chk_len           = {57'd0, rx_byte[6:0]};
          chk_hlen          = 4'd2;
          chk_run           = 1'b1;
        end
      end
      PH_EXT: begin
        payload_left_next = {payload_left[55:0], rx_byte};
        ext_len_left_next = ext_len_left - 4'd1;
        if (ext_len_left == 4'd1) begin
          chk_len  = {payload_left[55:0], rx_byte};
          chk_hlen = header_len;
          chk_run  = 1'b1;
        end
      end
      PH_BODY: begin
        payload_left_next = body_dec;
        if (body_end) begin
          phase_next = PH_FLAGS;
        end
        if ((frame_opcode == wsfp_pkg::OP_TEXT || frame_opcode == wsfp_pkg::OP_BINARY)
            && fin_flag) begin
          push                = 1'b1;
          push_data.kind      = wsfp_pkg::KIND_MSG;
          push_data.data_byte = rx_byte;
          push_data.last      = body_end;
          push_data.is_binary = (frame_opcode == wsfp_pkg::OP_BINARY);
        end else if (frame_opcode == wsfp_pkg::OP_PING) begin
          push                = 1'b1;
          push_data.kind      = wsfp_pkg::KIND_PING_BYTE;
          push_data.data_byte = rx_byte;
          push_data.last      = body_end;
        end else if (frame_opcode == wsfp_pkg::OP_CLOSE) begin
          if (close_bytes_seen != 2'd2) begin
            close_status_next     = {close_status[7:0], rx_byte};
            close_bytes_seen_next = close_bytes_seen + 2'd1;
          end
          if (body_end) begin
            phase_next               = PH_HALT;
            push                     = 1'b1;
            push_data.kind           = wsfp_pkg::KIND_CLOSE;
            push_data.close_code     = close_status_next;
            push_data.has_close_code = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase

    chk_total = {1'b0, chk_len[30:0]} + {28'd0, chk_hlen};
    opcode_ok = (chk_opcode_ok(frame_opcode));
    is_ctrl   = (frame_opcode == wsfp_pkg::OP_PING) || (frame_opcode == wsfp_pkg::OP_PONG);

    if (chk_run) begin
      if (chk_len[63] && (chk_len[62:0] != 63'd0)) begin
        phase_next           = PH_HALT;
        push                 = 1'b1;
        push_data.kind       = wsfp_pkg::KIND_ERROR;
        push_data.error_code = wsfp_pkg::ERR_TOO_LONG;
      end else if (masked_flag_next) begin
        phase_next           = PH_HALT;
        push                 = 1'b1;
        push_data.kind       = wsfp_pkg::KIND_ERROR;
        push_data.error_code = wsfp_pkg::ERR_MASKED;
      end else if ((chk_len[63:31] != 33'd0) || (chk_total > {1'b0, max_frame_len})) begin
        phase_next           = PH_HALT;
        push                 = 1'b1;
        push_data.kind       = wsfp_pkg::KIND_ERROR;
        push_data.error_code = wsfp_pkg::ERR_TOO_LONG;
      end else if (!opcode_ok) begin
        phase_next           = PH_HALT;
        push                 = 1'b1;
        push_data.kind       = wsfp_pkg::KIND_ERROR;
        push_data.error_code = wsfp_pkg::ERR_BAD_OPCODE;
      end else if (is_ctrl && (!fin_flag || (chk_len[30:7] != 24'd0)
                               || (chk_len[6:0] > wsfp_pkg::CTRL_MAX))) begin
        phase_next           = PH_HALT;
        push                 = 1'b1;
        push_data.kind       = wsfp_pkg::KIND_ERROR;
        push_data.error_code = wsfp_pkg::ERR_BAD_CONTROL;
      end else if ((frame_opcode == wsfp_pkg::OP_CLOSE) && (chk_len[30:0] == 31'd1)) begin
        phase_next           = PH_HALT;
        push                 = 1'b1;
        push_data.kind       = wsfp_pkg::KIND_ERROR;
        push_data.error_code = wsfp_pkg::ERR_CLOSE_ONE;
      end else begin
        close_status_next     = '0;
        close_bytes_seen_next = '0;
        if (chk_len[30:0] != 31'd0) begin
          phase_next = PH_BODY;
        end else if (frame_opcode == wsfp_pkg::OP_CLOSE) begin
          phase_next     = PH_HALT;
          push           = 1'b1;
          push_data.kind = wsfp_pkg::KIND_CLOSE;
        end else begin
          phase_next = PH_FLAGS;
          if (frame_opcode == wsfp_pkg::OP_PING) begin
            push           = 1'b1;
            push_data.kind = wsfp_pkg::KIND_PING_EMPTY;
          end
        end
      end
    end

    if (!in_accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_FLAGS;
      max_frame_len    <= wsfp_pkg::MAX_FRAME_RESET;
      fin_flag         <= 1'b0;
      frame_opcode     <= '0;
      masked_flag      <= 1'b0;
      ext_len_left     <= '0;
      header_len       <= '0;
      payload_left     <= '0;
      close_status     <= '0;
      close_bytes_seen <= '0;
    end else begin
      if (cfg_write) begin
        max_frame_len <= cfg_value;
      end
      if (in_accept) begin
        phase            <= phase_next;
        fin_flag         <= fin_flag_next;
        frame_opcode     <= frame_opcode_next;
        masked_flag      <= masked_flag_next;
        ext_len_left     <= ext_len_left_next;
        header_len       <= header_len_next;
        payload_left     <= payload_left_next;
        close_status     <= close_status_next;
        close_bytes_seen <= close_bytes_seen_next;
      end
    end
  end

endmodule

// File: hdl/wsfp_queue.sv
// ---------------------------------------------------------------------------
// wsfp_queue
// Short result queue between the header walker and the output stage.
// ---------------------------------------------------------------------------
module wsfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  wsfp_pkg::wsfp_result_t push_data,
  input  logic                   pop,
  output logic                   has_room,
  output logic                   not_empty,
  output wsfp_pkg::wsfp_result_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  wsfp_pkg::wsfp_result_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign has_room  = (count != FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && has_room;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/wsfp_out.sv
// ---------------------------------------------------------------------------
// wsfp_out
// Output register: takes records from the queue and presents them on the
// master stream, packed into tdata, tuser and tlast.
// ---------------------------------------------------------------------------
module wsfp_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  wsfp_pkg::wsfp_result_t q_head,
  output logic                   q_pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,
  output logic [7:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  assign q_pop = q_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_axis_tdata <= {5'd0, q_head.error_code, q_head.close_code, q_head.data_byte};
      m_axis_tuser <= {3'd0, q_head.has_close_code, q_head.is_binary, q_head.kind};
      m_axis_tlast <= q_head.last;
    end
  end

endmodule

// File: hdl/websocket_frame_parser_unit.sv
// ---------------------------------------------------------------------------
// websocket_frame_parser_unit
// Client-side WebSocket deframer: walks server frame headers byte by byte,
// passes unfragmented message and ping payload, reports close and protocol errors.
// ---------------------------------------------------------------------------
//
//  Channel    Direction  Payload                         Transfer when
//  s_axis     in         rx_byte (8 bit)                 s_axis_tvalid & s_axis_tready
//  m_axis     out        one result record               m_axis_tvalid & m_axis_tready
//  cfg        in         max_frame_len (31 bit)          cfg_valid & cfg_ready
//
//  The header walker handles each byte as it is accepted, so a new byte can be
//  accepted in every cycle while the queue has room; the sustained rate is one
//  byte per clock while m_axis does not stall. A byte's result is written into
//  the queue when the byte is taken; the output register then loads it from
//  the queue, and it transfers on m_axis from there. Reset (rst, synchronous)
//  empties the queue and returns the walker to the first header byte with the
//  frame limit at its maximum. A stall on m_axis holds one record in the
//  output register and then fills the queue (QUEUE_DEPTH more records);
//  s_axis_tready drops only when the queue is full. cfg_ready is always high.
//
//  The block is split into a front end (header walker, wsfp_front), a short
//  record queue (wsfp_queue) and a back end (output register, wsfp_out), so
//  input and output can stall independently. After a close or an error has
//  been reported, the walker keeps accepting bytes but produces nothing more
//  until reset.
// ---------------------------------------------------------------------------
module websocket_frame_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Received byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [23:8] close_code,
                                      // [26:24] error_code, [31:27] zero
  output logic [7:0]  m_axis_tuser,   // [2:0] kind, [3] is_binary,
                                      // [4] has_close_code, [7:5] zero
  output logic        m_axis_tlast,   // last
  // Frame size limit register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data        // max_frame_len
);

  logic                   in_accept;
  logic                   push;
  wsfp_pkg::wsfp_result_t push_data;
  logic                   q_room;
  logic                   q_valid;
  logic                   q_pop;
  wsfp_pkg::wsfp_result_t q_head;

  // The walker never emits more than one record per byte, so a free queue
  // slot is all that is needed to take the next byte.
  assign s_axis_tready = q_room;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  wsfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .rx_byte   (s_axis_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .push      (push),
    .push_data (push_data)
  );

  wsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .has_room  (q_room),
    .not_empty (q_valid),
    .head      (q_head)
  );

  wsfp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/wsfp_checker.sv
// ---------------------------------------------------------------------------
// wsfp_checker
// Port-level checks for the WebSocket frame parser, bound to the top level.
// ---------------------------------------------------------------------------
module wsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic out_xfer;
  logic payload_kind;
  logic final_kind;

  assign out_xfer     = m_axis_tvalid && m_axis_tready;
  assign payload_kind = (m_axis_tuser[2:0] == wsfp_pkg::KIND_MSG) ||
                        (m_axis_tuser[2:0] == wsfp_pkg::KIND_PING_BYTE);
  assign final_kind   = (m_axis_tuser[2:0] == wsfp_pkg::KIND_CLOSE) ||
                        (m_axis_tuser[2:0] == wsfp_pkg::KIND_ERROR);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Close or error is the last thing the block ever reports.
  a_final: assert property (@(posedge clk) disable iff (rst)
    out_xfer && final_kind |=> !m_axis_tvalid)
    else $error("result after close or error");

  // Only payload records carry a data byte or a last flag.
  a_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !payload_kind |-> m_axis_tdata[7:0] == 8'd0 && !m_axis_tlast)
    else $error("data on a non-payload record");

  // Error codes appear only on error records, close codes only on close records.
  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser[2:0] == wsfp_pkg::KIND_ERROR || m_axis_tdata[26:24] == 3'd0)
      && (m_axis_tuser[2:0] == wsfp_pkg::KIND_CLOSE || m_axis_tdata[23:8] == 16'd0))
    else $error("code field on wrong record kind");

endmodule

bind websocket_frame_parser_unit wsfp_checker u_wsfp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
